FILE: hw/rtl/nutrient_tank_sequencer_assert.svh
// assertion macros used by the checker file
`ifndef NUTRIENT_TANK_SEQUENCER_ASSERT_SVH
`define NUTRIENT_TANK_SEQUENCER_ASSERT_SVH

`define NTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define NTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/nts_pkg.sv
`default_nettype none
package nts_pkg;

  typedef enum logic [2:0] {
    ST_INIT  = 3'd0,
    ST_MON   = 3'd1,
    ST_FILL  = 3'd2,
    ST_COND  = 3'd3,
    ST_REL   = 3'd4,
    ST_FAULT = 3'd5
  } seq_state_e;

  localparam logic [3:0] FC_NONE     = 4'd0;
  localparam logic [3:0] FC_INIT     = 4'd1;
  localparam logic [3:0] FC_US_MON   = 4'd2;
  localparam logic [3:0] FC_REAGENT  = 4'd3;
  localparam logic [3:0] FC_US_FILL  = 4'd4;
  localparam logic [3:0] FC_FILL_TMO = 4'd5;
  localparam logic [3:0] FC_PH       = 4'd6;
  localparam logic [3:0] FC_TDS      = 4'd7;
  localparam logic [3:0] FC_UP_EMPTY = 4'd8;
  localparam logic [3:0] FC_DN_EMPTY = 4'd9;
  localparam logic [3:0] FC_NU_EMPTY = 4'd10;
  localparam logic [3:0] FC_COND_TMO = 4'd11;
  localparam logic [3:0] FC_FLOW     = 4'd12;
  localparam logic [3:0] FC_REL_TMO  = 4'd13;

  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_UP   = 2'd1;
  localparam logic [1:0] PK_DN   = 2'd2;
  localparam logic [1:0] PK_NU   = 2'd3;

  localparam int H_FULL = 0;
  localparam int H_EMPTY = 1;
  localparam int H_FLOW = 2;
  localparam int H_US_MON = 3;
  localparam int H_US_FILL = 4;
  localparam int H_PH = 5;
  localparam int H_TDS = 6;
  localparam int NHOLD = 7;

  localparam logic [2:0] REG_PERSIST = 3'd0;
  localparam logic [2:0] REG_FILL    = 3'd1;
  localparam logic [2:0] REG_COND    = 3'd2;
  localparam logic [2:0] REG_REL     = 3'd3;
  localparam logic [2:0] REG_PULSE   = 3'd4;
  localparam logic [2:0] REG_GAP     = 3'd5;
  localparam logic [2:0] REG_FULL    = 3'd6;
  localparam logic [2:0] REG_LOW     = 3'd7;

  typedef struct packed {
    logic [15:0] persist_ms;
    logic [21:0] fill_limit_ms;
    logic [21:0] condition_limit_ms;
    logic [21:0] release_limit_ms;
    logic [15:0] dose_pulse_ms;
    logic [15:0] dose_gap_ms;
    logic [11:0] level_full_dtcm;
    logic [11:0] level_low_dtcm;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [11:0]        distance_dtcm;
    logic [10:0]        ph_centi;
    logic [15:0]        tds_dppm;
    logic signed [11:0] temp_dc;
    logic [23:0]        light_clux;
    logic [13:0]        flow_clpm;
    logic [5:0]         valid_bits;
    logic [3:0]         reagent_bits;
    logic               clear_fault;
    logic [4:0]         clock_hour;
    logic [15:0]        plant_age_days;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  fault_code;
    logic [6:0]  actuator_bits;
    logic        temp_alarm;
    logic        fault_alarm;
    logic [2:0]  grow_week;
    logic [12:0] tds_target_dppm;
    logic [15:0] grow_day;
  } out_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/nts_stream_if.sv
`default_nettype none
interface nts_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/nts_cfg_regs.sv
`default_nettype none
module nts_cfg_regs import nts_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);
  cfg_t cfg_q;
  logic [2:0] idx;
  logic wr;

  assign idx = paddr[4:2];
  assign wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.persist_ms <= 16'd3000;
      cfg_q.fill_limit_ms <= 22'd300000;
      cfg_q.condition_limit_ms <= 22'd600000;
      cfg_q.release_limit_ms <= 22'd300000;
      cfg_q.dose_pulse_ms <= 16'd2000;
      cfg_q.dose_gap_ms <= 16'd10000;
      cfg_q.level_full_dtcm <= 12'd300;
      cfg_q.level_low_dtcm <= 12'd800;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        REG_PERSIST: cfg_q.persist_ms <= pwdata[15:0];
        REG_FILL:    cfg_q.fill_limit_ms <= pwdata[21:0];
        REG_COND:    cfg_q.condition_limit_ms <= pwdata[21:0];
        REG_REL:     cfg_q.release_limit_ms <= pwdata[21:0];
        REG_PULSE:   cfg_q.dose_pulse_ms <= pwdata[15:0];
        REG_GAP:     cfg_q.dose_gap_ms <= pwdata[15:0];
        REG_FULL:    cfg_q.level_full_dtcm <= pwdata[11:0];
        REG_LOW:     cfg_q.level_low_dtcm <= pwdata[11:0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERSIST: prdata = {16'd0, cfg_q.persist_ms};
      REG_FILL:    prdata = {10'd0, cfg_q.fill_limit_ms};
      REG_COND:    prdata = {10'd0, cfg_q.condition_limit_ms};
      REG_REL:     prdata = {10'd0, cfg_q.release_limit_ms};
      REG_PULSE:   prdata = {16'd0, cfg_q.dose_pulse_ms};
      REG_GAP:     prdata = {16'd0, cfg_q.dose_gap_ms};
      REG_FULL:    prdata = {20'd0, cfg_q.level_full_dtcm};
      REG_LOW:     prdata = {20'd0, cfg_q.level_low_dtcm};
      default:     prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/nts_core.sv
`default_nettype none
module nts_core import nts_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  in_item_t       item_i,
  input  cfg_t           cfg_i,
  output out_item_t      res_o
);
  seq_state_e  st_q, st_d;
  logic [31:0] ent_q, ent_d;
  logic [3:0]  flt_q, flt_d;
  logic [2:0]  dem_q, dem_d;
  logic        buzz_q, buzz_d, light_q, light_d;
  logic [NHOLD-1:0] ha_q, ha_d;
  logic [31:0] hs_q [NHOLD];
  logic [31:0] hs_d [NHOLD];
  logic [1:0]  pk_q, pk_d;
  logic [31:0] pe_q, pe_d, lp_q, lp_d;
  logic        dosed_q, dosed_d, armed_q;

  logic [31:0] now, ent_eff, elapsed, persist;
  logic dv, pv, tv, tempv, lv, fv, r_up, r_dn, r_a, r_b;
  logic [15:0] day;
  logic [2:0] week;
  logic [12:0] target;
  logic [16:0] tgt_hi;
  logic [NHOLD-1:0] cond, hres;
  logic up, dn, nu, water, pulse_live;
  logic [6:0] act;
  seq_state_e nxt;
  logic [3:0] code;
  logic do_pulse;
  logic [1:0] pkind;

  assign now = item_i.now_ms;
  assign {fv, lv, tempv, tv, pv, dv} = item_i.valid_bits;
  assign {r_b, r_a, r_dn, r_up} = item_i.reagent_bits;
  assign persist = {16'd0, cfg_i.persist_ms};
  assign ent_eff = armed_q ? ent_q : now;
  assign elapsed = now - ent_eff;

  always_comb begin
    day = (item_i.plant_age_days == 16'd0) ? 16'd1 : item_i.plant_age_days;
    if (day <= 16'd7) begin week = 3'd1; target = 13'd5000; end
    else if (day <= 16'd14) begin week = 3'd2; target = 13'd6000; end
    else if (day <= 16'd21) begin week = 3'd3; target = 13'd7000; end
    else if (day <= 16'd35) begin week = 3'd4; target = 13'd8000; end
    else begin week = 3'd5; target = 13'd8000; end
    tgt_hi = {4'd0, target} + 17'd50;
  end

  always_comb begin
    cond = '0;
    cond[H_FULL] = dv && item_i.distance_dtcm <= cfg_i.level_full_dtcm;
    cond[H_EMPTY] = dv && item_i.distance_dtcm >= cfg_i.level_low_dtcm;
    cond[H_FLOW] = !fv || item_i.flow_clpm == 14'd0;
    cond[H_US_MON] = !dv;
    cond[H_US_FILL] = !dv;
    cond[H_PH] = !pv;
    cond[H_TDS] = !tv;
  end

  always_comb begin
    ha_d = ha_q;
    for (int k = 0; k < NHOLD; k++) begin
      hs_d[k] = hs_q[k];
      hres[k] = 1'b0;
    end
    buzz_d = buzz_q;
    if (!tempv) buzz_d = 1'b0;
    else if (item_i.temp_dc < 12'sd245 || item_i.temp_dc > 12'sd285) buzz_d = 1'b1;
    else if (item_i.temp_dc <= 12'sd255 || item_i.temp_dc >= 12'sd275) buzz_d = buzz_q;
    else buzz_d = 1'b0;

    nxt = st_q; code = FC_NONE;
    dem_d = dem_q; do_pulse = 1'b0; pkind = PK_NONE;
    up = dem_q[0]; dn = dem_q[1]; nu = dem_q[2];
    case (st_q)
      ST_INIT, ST_FAULT: begin
      end
      ST_MON: begin
        for (int k = H_US_MON; k <= H_US_MON; k++) begin
          if (!cond[k]) ha_d[k] = 1'b0;
          else begin
            if (!ha_q[k]) begin ha_d[k] = 1'b1; hs_d[k] = now; end
            hres[k] = (now - hs_d[k]) >= persist;
          end
        end
      end
      ST_FILL: begin
        for (int k = H_FULL; k <= H_US_FILL; k += H_US_FILL) begin
          if (!cond[k]) ha_d[k] = 1'b0;
          else begin
            if (!ha_q[k]) begin ha_d[k] = 1'b1; hs_d[k] = now; end
            hres[k] = (now - hs_d[k]) >= persist;
          end
        end
      end
      ST_COND: begin
        for (int k = H_PH; k <= H_TDS; k++) begin
          if (!cond[k]) ha_d[k] = 1'b0;
          else begin
            if (!ha_q[k]) begin ha_d[k] = 1'b1; hs_d[k] = now; end
            hres[k] = (now - hs_d[k]) >= persist;
          end
        end
      end
      ST_REL: begin
        for (int k = H_EMPTY; k <= H_FLOW; k++) begin
          if (!cond[k]) ha_d[k] = 1'b0;
          else begin
            if (!ha_q[k]) begin ha_d[k] = 1'b1; hs_d[k] = now; end
            hres[k] = (now - hs_d[k]) >= persist;
          end
        end
      end
      default: begin
      end
    endcase

    case (st_q)
      ST_INIT: begin
        if (dv && pv && tv) nxt = ST_MON;
        else if (elapsed >= persist) begin nxt = ST_FAULT; code = FC_INIT; end
      end
      ST_MON: begin
        if (hres[H_US_MON]) begin nxt = ST_FAULT; code = FC_US_MON; end
        else if (!(r_up && r_dn && r_a && r_b)) begin nxt = ST_FAULT; code = FC_REAGENT; end
        else if (dv && item_i.distance_dtcm >= cfg_i.level_low_dtcm) nxt = ST_FILL;
      end
      ST_FILL: begin
        if (hres[H_US_FILL]) begin nxt = ST_FAULT; code = FC_US_FILL; end
        else if (hres[H_FULL]) begin
          ha_d[H_FULL] = 1'b0; hs_d[H_FULL] = '0; nxt = ST_COND;
        end else if (elapsed > {10'd0, cfg_i.fill_limit_ms}) begin
          nxt = ST_FAULT; code = FC_FILL_TMO;
        end
      end
      ST_COND: begin
        if (hres[H_PH] || hres[H_TDS]) begin
          nxt = ST_FAULT; code = hres[H_PH] ? FC_PH : FC_TDS;
        end else if (pv && tv) begin
          if (item_i.ph_centi < 11'd600) up = 1'b1;
          else if (item_i.ph_centi > 11'd620) up = 1'b0;
          if (item_i.ph_centi > 11'd700) dn = 1'b1;
          else if (item_i.ph_centi < 11'd680) dn = 1'b0;
          if (up && dn) begin up = 1'b0; dn = 1'b0; end
          if (item_i.tds_dppm < {3'd0, target}) nu = 1'b1;
          else if ({1'b0, item_i.tds_dppm} > tgt_hi) nu = 1'b0;
          dem_d = {nu, dn, up};
          if (up && !r_up) begin nxt = ST_FAULT; code = FC_UP_EMPTY; end
          else if (dn && !r_dn) begin nxt = ST_FAULT; code = FC_DN_EMPTY; end
          else if (nu && (!r_a || !r_b)) begin nxt = ST_FAULT; code = FC_NU_EMPTY; end
          else if (up) begin do_pulse = 1'b1; pkind = PK_UP; end
          else if (dn) begin do_pulse = 1'b1; pkind = PK_DN; end
          else if (nu) begin do_pulse = 1'b1; pkind = PK_NU; end
          else if (item_i.ph_centi >= 11'd600 && item_i.ph_centi <= 11'd700
                   && item_i.tds_dppm >= {3'd0, target}
                   && {1'b0, item_i.tds_dppm} <= tgt_hi) nxt = ST_REL;
          else if (elapsed > {10'd0, cfg_i.condition_limit_ms}) begin
            nxt = ST_FAULT; code = FC_COND_TMO;
          end
        end
      end
      ST_REL: begin
        if (hres[H_EMPTY]) begin
          ha_d[H_EMPTY] = 1'b0; hs_d[H_EMPTY] = '0;
          ha_d[H_FLOW] = 1'b0; hs_d[H_FLOW] = '0;
          nxt = ST_MON;
        end else if (hres[H_FLOW]) begin nxt = ST_FAULT; code = FC_FLOW; end
        else if (elapsed > {10'd0, cfg_i.release_limit_ms}) begin
          nxt = ST_FAULT; code = FC_REL_TMO;
        end
      end
      ST_FAULT: begin
        if (item_i.clear_fault) nxt = ST_INIT;
      end
      default: nxt = ST_INIT;
    endcase

    st_d = nxt;
    ent_d = ent_eff;
    flt_d = flt_q;
    pk_d = pk_q; pe_d = pe_q; lp_d = lp_q; dosed_d = dosed_q;
    if (nxt != st_q) begin
      ent_d = now;
      if (nxt == ST_FAULT) flt_d = code;
      else if (nxt == ST_INIT) flt_d = FC_NONE;
    end
    if (do_pulse) begin
      if (!(pk_q != PK_NONE && (now - pe_q) >= 32'h8000_0000) &&
          !(dosed_q && (now - lp_q) < {16'd0, cfg_i.dose_gap_ms})) begin
        pk_d = pkind; pe_d = now + {16'd0, cfg_i.dose_pulse_ms};
        lp_d = now; dosed_d = 1'b1;
      end
    end

    water = (st_q == ST_FILL);
    act = '0;
    if (nxt == ST_COND) begin
      pulse_live = pk_d != PK_NONE && (now - pe_d) >= 32'h8000_0000;
      if (!pulse_live) pk_d = PK_NONE;
      else act[pk_d - 2'd1] = 1'b1;
      act[6] = 1'b1;
      if (water) act[3] = 1'b1;
    end else begin
      pulse_live = 1'b0;
      pk_d = PK_NONE; pe_d = '0;
      if (nxt == ST_FILL) act[3] = 1'b1;
      else if (nxt == ST_REL) begin act[4] = 1'b1; act[6] = 1'b1; end
    end

    light_d = light_q;
    if (!lv || item_i.clock_hour > 5'd23 || nxt == ST_INIT || nxt == ST_FAULT
        || item_i.clock_hour < 5'd7 || item_i.clock_hour >= 5'd19) light_d = 1'b0;
    else if (item_i.light_clux < 24'd215278) light_d = 1'b1;
    else if (item_i.light_clux > 24'd265278) light_d = 1'b0;
    if (light_d) act[5] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_INIT; ent_q <= '0; flt_q <= FC_NONE; dem_q <= '0;
      buzz_q <= 1'b0; light_q <= 1'b0; ha_q <= '0; pk_q <= PK_NONE;
      pe_q <= '0; lp_q <= '0; dosed_q <= 1'b0; armed_q <= 1'b0;
      for (int k = 0; k < NHOLD; k++) hs_q[k] <= '0;
    end else if (step_i) begin
      st_q <= st_d; ent_q <= ent_d; flt_q <= flt_d; dem_q <= dem_d;
      buzz_q <= buzz_d; light_q <= light_d; ha_q <= ha_d; pk_q <= pk_d;
      pe_q <= pe_d; lp_q <= lp_d; dosed_q <= dosed_d; armed_q <= 1'b1;
      for (int k = 0; k < NHOLD; k++) hs_q[k] <= hs_d[k];
    end
  end

  always_comb begin
    res_o.mode = nxt;
    res_o.fault_code = flt_d;
    res_o.actuator_bits = act;
    res_o.temp_alarm = buzz_d;
    res_o.fault_alarm = (nxt == ST_FAULT);
    res_o.grow_week = week;
    res_o.tds_target_dppm = target;
    res_o.grow_day = day;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/nutrient_tank_sequencer.sv
// channel  dir  payload     transfer
// in_if    in   in_item_t   valid & ready
// out_if   out  out_item_t  valid & ready
// cfg      in   apb         psel & penable & pwrite
// one item per cycle while the output is not stalled: input register, one combinational step, result register
// result valid once the item has passed the input register and been stepped into the result register
// rst_ni clears state and loads register defaults
// input ready while the input register is free or moves forward this cycle
`default_nettype none
module nutrient_tank_sequencer import nts_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  nts_stream_if.sink       in_if,
  nts_stream_if.source     out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  cfg_t cfg;
  in_item_t in_q;
  logic in_v_q, out_v_q, step;
  out_item_t res, out_q;

  nts_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  assign step = in_v_q && (!out_v_q || out_if.ready);
  assign in_if.ready = !in_v_q || step;

  nts_core u_core (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_q), .cfg_i(cfg), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      if (in_if.ready) in_v_q <= in_if.valid;
      if (step) out_v_q <= 1'b1;
      else if (out_if.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) in_q <= in_if.data;
    if (step) out_q <= res;
  end

  assign out_if.valid = out_v_q;
  assign out_if.data = out_q;
endmodule
`default_nettype wire

FILE: hw/rtl/nts_checker.sv
`default_nettype none
`include "nutrient_tank_sequencer_assert.svh"
module nts_checker import nts_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid,
  input wire logic out_ready,
  input out_item_t out_data,
  input wire logic pready
);
  `NTS_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)
  `NTS_ASSERT_IMP(a_alarm, clk_i, rst_ni, out_valid, out_data.fault_alarm == (out_data.mode == ST_FAULT))
  `NTS_ASSERT_IMP(a_fault_act, clk_i, rst_ni, out_valid && out_data.fault_alarm, out_data.actuator_bits == 7'd0)
  `NTS_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind nutrient_tank_sequencer nts_checker u_chk (
  .clk_i, .rst_ni, .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data(out_if.data), .pready
);
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import nts_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nts_stream_if #(.T(in_item_t))  in_if ();
  nts_stream_if #(.T(out_item_t)) out_if ();

  nutrient_tank_sequencer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  localparam int REG_WIDTH [8] = '{16, 22, 22, 22, 16, 16, 12, 12};

  // tank model state
  logic [31:0] tank_reg [8];
  seq_state_e  tank_state;
  logic [31:0] stage_entered;
  logic [3:0]  tank_fault;
  logic [2:0]  demand;
  logic        buzz_on;
  logic        light_on;
  logic        hold_on [NHOLD];
  logic [31:0] hold_t0 [NHOLD];
  logic [1:0]  pulse_kind;
  logic [31:0] pulse_end;
  logic [31:0] last_pulse;
  logic        dosed;
  logic        first_tick_seen;

  out_item_t   pending_results [$];
  int          errors;
  logic        calm;
  logic [31:0] tick_clock;
  int          step_max;

  always #5 clk_i = ~clk_i;

  function automatic bit persist_hold(int k, bit cond, logic [31:0] now);
    if (!cond) begin
      hold_on[k] = 1'b0;
      return 1'b0;
    end
    if (!hold_on[k]) begin
      hold_on[k] = 1'b1;
      hold_t0[k] = now;
    end
    return (now - hold_t0[k]) >= tank_reg[REG_PERSIST];
  endfunction

  function automatic void hold_reset(int k);
    hold_on[k] = 1'b0;
    hold_t0[k] = '0;
  endfunction

  function automatic bit deadline_hit(logic [31:0] now, logic [31:0] deadline);
    logic [31:0] d;
    d = now - deadline;
    return !d[31];
  endfunction

  function automatic void tank_go(seq_state_e nxt, logic [31:0] now, logic [3:0] code);
    if (tank_state == nxt) return;
    tank_state = nxt;
    stage_entered = now;
    if (nxt == ST_FAULT) tank_fault = code;
    else if (nxt == ST_INIT) tank_fault = FC_NONE;
    if (nxt != ST_COND) begin
      pulse_kind = PK_NONE;
      pulse_end = '0;
    end
  endfunction

  function automatic void dose_start(logic [1:0] kind, logic [31:0] now);
    if (pulse_kind != PK_NONE && !deadline_hit(now, pulse_end)) return;
    if (dosed && (now - last_pulse) < tank_reg[REG_GAP]) return;
    pulse_kind = kind;
    pulse_end = now + tank_reg[REG_PULSE];
    last_pulse = now;
    dosed = 1'b1;
  endfunction

  function automatic int week_target(logic [15:0] day);
    if (day <= 7) return 5000;
    if (day <= 14) return 6000;
    if (day <= 21) return 7000;
    return 8000;
  endfunction

  function automatic out_item_t tank_tick(in_item_t it);
    out_item_t   r;
    logic [31:0] now;
    logic [15:0] day;
    int          temp;
    int          target;
    int          ph;
    int          tds;
    bit          dv, pv, tv, tempv, lv, fv;
    bit          r_up, r_dn, r_a, r_b;
    bit          usf, full, tmo, phf, tdf, up, dn, nu, empty, noflow;
    logic [6:0]  act;
    seq_state_e  start_state;
    now = it.now_ms;
    day = (it.plant_age_days == 0) ? 16'd1 : it.plant_age_days;
    temp = $signed(it.temp_dc);
    target = week_target(day);
    ph = it.ph_centi;
    tds = it.tds_dppm;
    {fv, lv, tempv, tv, pv, dv} = it.valid_bits;
    {r_b, r_a, r_dn, r_up} = it.reagent_bits;
    act = '0;
    if (!first_tick_seen) begin
      first_tick_seen = 1'b1;
      stage_entered = now;
    end
    if (!tempv) buzz_on = 1'b0;
    else if (temp < 245 || temp > 285) buzz_on = 1'b1;
    else if (!(temp <= 255 || temp >= 275)) buzz_on = 1'b0;
    start_state = tank_state;
    case (tank_state)
      ST_INIT: begin
        if (dv && pv && tv) tank_go(ST_MON, now, FC_NONE);
        else if ((now - stage_entered) >= tank_reg[REG_PERSIST]) tank_go(ST_FAULT, now, FC_INIT);
      end
      ST_MON: begin
        usf = persist_hold(H_US_MON, !dv, now);
        if (usf) tank_go(ST_FAULT, now, FC_US_MON);
        else if (!(r_up && r_dn && r_a && r_b)) tank_go(ST_FAULT, now, FC_REAGENT);
        else if (dv && it.distance_dtcm >= tank_reg[REG_LOW]) tank_go(ST_FILL, now, FC_NONE);
      end
      ST_FILL: begin
        usf = persist_hold(H_US_FILL, !dv, now);
        full = persist_hold(H_FULL, dv && it.distance_dtcm <= tank_reg[REG_FULL], now);
        tmo = (now - stage_entered) > tank_reg[REG_FILL];
        if (usf) tank_go(ST_FAULT, now, FC_US_FILL);
        else if (full) begin
          hold_reset(H_FULL);
          tank_go(ST_COND, now, FC_NONE);
        end else if (tmo) tank_go(ST_FAULT, now, FC_FILL_TMO);
      end
      ST_COND: begin
        phf = persist_hold(H_PH, !pv, now);
        tdf = persist_hold(H_TDS, !tv, now);
        tmo = (now - stage_entered) > tank_reg[REG_COND];
        if (phf || tdf) tank_go(ST_FAULT, now, phf ? FC_PH : FC_TDS);
        else if (pv && tv) begin
          {nu, dn, up} = demand;
          if (ph < 600) up = 1'b1; else if (ph > 620) up = 1'b0;
          if (ph > 700) dn = 1'b1; else if (ph < 680) dn = 1'b0;
          if (up && dn) begin
            up = 1'b0;
            dn = 1'b0;
          end
          if (tds < target) nu = 1'b1; else if (tds > target + 50) nu = 1'b0;
          demand = {nu, dn, up};
          if (up && !r_up) tank_go(ST_FAULT, now, FC_UP_EMPTY);
          else if (dn && !r_dn) tank_go(ST_FAULT, now, FC_DN_EMPTY);
          else if (nu && (!r_a || !r_b)) tank_go(ST_FAULT, now, FC_NU_EMPTY);
          else if (up) dose_start(PK_UP, now);
          else if (dn) dose_start(PK_DN, now);
          else if (nu) dose_start(PK_NU, now);
          else if (ph >= 600 && ph <= 700 && tds >= target && tds <= target + 50)
            tank_go(ST_REL, now, FC_NONE);
          else if (tmo) tank_go(ST_FAULT, now, FC_COND_TMO);
        end
      end
      ST_REL: begin
        empty = persist_hold(H_EMPTY, dv && it.distance_dtcm >= tank_reg[REG_LOW], now);
        noflow = persist_hold(H_FLOW, !fv || it.flow_clpm == 0, now);
        tmo = (now - stage_entered) > tank_reg[REG_REL];
        if (empty) begin
          hold_reset(H_EMPTY);
          hold_reset(H_FLOW);
          tank_go(ST_MON, now, FC_NONE);
        end else if (noflow) tank_go(ST_FAULT, now, FC_FLOW);
        else if (tmo) tank_go(ST_FAULT, now, FC_REL_TMO);
      end
      default: begin
        if (it.clear_fault) tank_go(ST_INIT, now, FC_NONE);
      end
    endcase
    if (tank_state == ST_COND) begin
      if (pulse_kind == PK_NONE || deadline_hit(now, pulse_end)) pulse_kind = PK_NONE;
      else act[pulse_kind - 1] = 1'b1;
      act[6] = 1'b1;
      if (start_state == ST_FILL) act[3] = 1'b1;
    end else begin
      pulse_kind = PK_NONE;
      pulse_end = '0;
      if (tank_state == ST_FILL) act[3] = 1'b1;
      else if (tank_state == ST_REL) act = act | 7'h50;
    end
    if (!lv || it.clock_hour > 23 || tank_state == ST_INIT || tank_state == ST_FAULT ||
        it.clock_hour < 7 || it.clock_hour >= 19)
      light_on = 1'b0;
    else if (it.light_clux < 24'd215278) light_on = 1'b1;
    else if (it.light_clux > 24'd265278) light_on = 1'b0;
    if (light_on) act[5] = 1'b1;
    r.mode = tank_state;
    r.fault_code = tank_fault;
    r.actuator_bits = act;
    r.temp_alarm = buzz_on;
    r.fault_alarm = (tank_state == ST_FAULT);
    r.grow_week = (day <= 7) ? 3'd1 : (day <= 14) ? 3'd2 : (day <= 21) ? 3'd3 :
                  (day <= 35) ? 3'd4 : 3'd5;
    r.tds_target_dppm = 13'(target);
    r.grow_day = day;
    return r;
  endfunction

  task automatic field_check(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // input transfers feed the model, output transfers are checked
  always @(posedge clk_i) begin
    out_item_t exp_r;
    out_item_t got_r;
    if (rst_ni && in_if.valid && in_if.ready) pending_results.push_back(tank_tick(in_if.data));
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_r = out_if.data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got_r);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        field_check("mode", exp_r.mode, got_r.mode);
        field_check("fault_code", exp_r.fault_code, got_r.fault_code);
        field_check("actuator_bits", exp_r.actuator_bits, got_r.actuator_bits);
        field_check("temp_alarm", exp_r.temp_alarm, got_r.temp_alarm);
        field_check("fault_alarm", exp_r.fault_alarm, got_r.fault_alarm);
        field_check("grow_week", exp_r.grow_week, got_r.grow_week);
        field_check("tds_target_dppm", exp_r.tds_target_dppm, got_r.tds_target_dppm);
        field_check("grow_day", exp_r.grow_day, got_r.grow_day);
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
  end

  task automatic send_tick(in_item_t it);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tank_reg[idx] = value & ((32'd1 << REG_WIDTH[idx]) - 1);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_config(logic [31:0] persist, logic [31:0] fill_lim, logic [31:0] cond_lim,
                             logic [31:0] rel_lim, logic [31:0] pulse, logic [31:0] gap,
                             logic [31:0] full_d, logic [31:0] low_d);
    wait_drain();
    reg_write(REG_PERSIST, persist);
    reg_write(REG_FILL, fill_lim);
    reg_write(REG_COND, cond_lim);
    reg_write(REG_REL, rel_lim);
    reg_write(REG_PULSE, pulse);
    reg_write(REG_GAP, gap);
    reg_write(REG_FULL, full_d);
    reg_write(REG_LOW, low_d);
  endtask

  function automatic in_item_t plain_tick(logic [31:0] now);
    in_item_t it;
    it = '0;
    it.now_ms = now;
    it.ph_centi = 11'd650;
    it.tds_dppm = 16'd5020;
    it.temp_dc = 12'sd200;
    it.light_clux = 24'd100000;
    it.flow_clpm = 14'd500;
    it.valid_bits = 6'h3f;
    it.reagent_bits = 4'hf;
    it.clock_hour = 5'd12;
    it.plant_age_days = 16'd3;
    it.distance_dtcm = 12'd500;
    return it;
  endfunction

  // sensor values steered by the current tank stage so the sequence gets deep
  function automatic in_item_t tank_item();
    in_item_t it;
    int       target;
    tick_clock = tick_clock + $urandom_range(0, step_max);
    it = plain_tick(tick_clock);
    if ($urandom_range(0, 99) < 8) begin
      it.distance_dtcm = 12'($urandom);
      it.ph_centi = 11'($urandom);
      it.tds_dppm = 16'($urandom);
      it.temp_dc = 12'($urandom);
      it.light_clux = 24'($urandom);
      it.flow_clpm = 14'($urandom);
      it.valid_bits = 6'($urandom);
      it.reagent_bits = 4'($urandom);
      it.clear_fault = 1'($urandom);
      it.clock_hour = 5'($urandom);
      it.plant_age_days = 16'($urandom);
      return it;
    end
    if ($urandom_range(0, 99) < 5) it.valid_bits = 6'($urandom);
    if ($urandom_range(0, 99) < 3) it.reagent_bits = 4'($urandom);
    it.clear_fault = (tank_state == ST_FAULT) ? ($urandom_range(0, 99) < 40)
                                              : ($urandom_range(0, 99) < 3);
    it.clock_hour = 5'($urandom_range(0, 24));
    it.plant_age_days = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    it.temp_dc = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 1650) - 400)
                                             : 12'($urandom_range(230, 300));
    it.light_clux = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 10000000))
                                                : 24'($urandom_range(200000, 280000));
    it.flow_clpm = ($urandom_range(0, 99) < 4) ? 14'd0 : 14'($urandom_range(1, 10000));
    if ($urandom_range(0, 99) < 20) it.distance_dtcm = 12'($urandom_range(0, 4000));
    else if (tank_state == ST_FILL || tank_state == ST_COND)
      it.distance_dtcm = 12'($urandom_range(0, tank_reg[REG_FULL]));
    else it.distance_dtcm = 12'($urandom_range(tank_reg[REG_LOW], 4000));
    target = week_target(it.plant_age_days == 0 ? 16'd1 : it.plant_age_days);
    it.ph_centi = ($urandom_range(0, 99) < 80) ? 11'($urandom_range(590, 710))
                                               : 11'($urandom_range(0, 1400));
    it.tds_dppm = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(target - 30, target + 80))
                                               : 16'($urandom_range(0, 50000));
    return it;
  endfunction

  task automatic run_ticks(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3 && i < count / 2);
      send_tick(tank_item());
    end
    calm = 1'b0;
  endtask

  task automatic test_directed();
    in_item_t it;
    it = plain_tick(0);
    it.valid_bits = 6'h00;
    send_tick(it);
    it.now_ms = 3000;
    it.plant_age_days = 16'd0;
    it.clock_hour = 5'd24;
    send_tick(it);
    it.clear_fault = 1'b1;
    it.now_ms = 3001;
    it.temp_dc = -12'sd400;
    send_tick(it);
    it = plain_tick(3002);
    it.reagent_bits = 4'h7;
    it.plant_age_days = 16'hffff;
    send_tick(it);
    it.clear_fault = 1'b1;
    it.temp_dc = 12'sd1250;
    send_tick(it);
    it = plain_tick(3010);
    send_tick(it);
    it.distance_dtcm = 12'd4000;
    it.light_clux = 24'hffffff;
    send_tick(it);
    it.distance_dtcm = 12'd0;
    it.now_ms = 4000;
    it.light_clux = 24'd0;
    send_tick(it);
    it.now_ms = 7000;
    send_tick(it);
    it.ph_centi = 11'd500;
    it.now_ms = 7001;
    send_tick(it);
    it.ph_centi = 11'd2047;
    it.now_ms = 20000;
    send_tick(it);
    it.ph_centi = 11'd650;
    it.tds_dppm = 16'd100;
    it.now_ms = 40000;
    send_tick(it);
    it.tds_dppm = 16'd5020;
    it.now_ms = 41000;
    send_tick(it);
    it.distance_dtcm = 12'd4000;
    it.flow_clpm = 14'h3fff;
    it.now_ms = 42000;
    send_tick(it);
    it.now_ms = 45000;
    send_tick(it);
    it.valid_bits = 6'h00;
    it.now_ms = 46000;
    send_tick(it);
    it.now_ms = 50000;
    send_tick(it);
    it = plain_tick(32'hffffffff);
    it.clear_fault = 1'b1;
    send_tick(it);
    tick_clock = 60000;
  endtask

  task automatic test_short_timers();
    load_config(50, 2000, 3000, 2000, 30, 100, 300, 800);
    step_max = 60;
    run_ticks(300);
    // let every result land before sending more
    wait_drain();
    run_ticks(200);
  endtask

  task automatic test_zero_limits();
    load_config(0, 0, 0, 0, 0, 0, 4000, 0);
    step_max = 3;
    run_ticks(150);
  endtask

  task automatic test_max_limits();
    load_config(32'hffff, 32'h3fffff, 32'h3fffff, 32'h3fffff, 32'hffff, 32'hffff, 0, 4000);
    step_max = 40000;
    tick_clock = 32'hfff00000;
    run_ticks(150);
  endtask

  task automatic test_random_config();
    for (int p = 0; p < 4; p++) begin
      load_config($urandom_range(0, 400), $urandom_range(0, 6000), $urandom_range(0, 8000),
                  $urandom_range(0, 6000), $urandom_range(0, 200), $urandom_range(0, 600),
                  $urandom_range(100, 600), $urandom_range(600, 1500));
      step_max = $urandom_range(5, 200);
      run_ticks(110);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    calm = 1'b0;
    errors = 0;
    tick_clock = 0;
    step_max = 100;
    tank_reg = '{3000, 300000, 600000, 300000, 2000, 10000, 300, 800};
    tank_state = ST_INIT;
    stage_entered = '0;
    tank_fault = FC_NONE;
    demand = '0;
    buzz_on = 1'b0;
    light_on = 1'b0;
    for (int k = 0; k < NHOLD; k++) hold_reset(k);
    pulse_kind = PK_NONE;
    pulse_end = '0;
    last_pulse = '0;
    dosed = 1'b0;
    first_tick_seen = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_short_timers();
    test_zero_limits();
    test_max_limits();
    test_random_config();
    wait_drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
